[design/cei_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder package
// Shared configuration and result types, register indexes and reset values.
// ----------------------------------------------------------------------------
package cei_pkg;

	// Register file layout.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIME    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EOF_TIME    = 2'd2;

	localparam logic [15:0] BIT_TIME_RST    = 16'd4;
	localparam logic [15:0] NOISE_LIMIT_RST = 16'd2;
	localparam logic [19:0] EOF_TIME_RST    = 20'd42;

	// Input field width and run limits.
	localparam int EDGE_W     = 20;
	localparam int RUN_LEN_W  = 3;
	localparam int RUN_MAX    = 5;

	// Depth of the queues between the parts of the block.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [15:0] bit_time;
		logic [15:0] noise_limit;
		logic [19:0] eof_time;
	} cfg_t;

	typedef struct packed {
		logic                 frame_start;
		logic                 run_level;
		logic [RUN_LEN_W-1:0] run_length;
	} result_t;

endpackage
`default_nettype wire

[design/cei_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder queue
// Small first-in first-out buffer in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module cei_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

[design/cei_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder front end
// Saturates the edge interval, drops glitches and flags long idle intervals.
// ----------------------------------------------------------------------------
module cei_front #(
	parameter int TIME_WIDTH = 20
) (
	input  wire cei_pkg::cfg_t              cfg,
	input  wire logic                       push,
	input  wire logic [cei_pkg::EDGE_W-1:0] edge_interval,
	input  wire logic                       mid_full,
	output logic                            mid_push,
	output logic [TIME_WIDTH:0]             mid_data
);

	localparam int CMP_W = (TIME_WIDTH > cei_pkg::EDGE_W) ? TIME_WIDTH : cei_pkg::EDGE_W;

	logic [TIME_WIDTH-1:0] t_sat;
	logic                  glitch;
	logic                  long_idle;

	generate
		if (TIME_WIDTH >= cei_pkg::EDGE_W) begin : g_wide
			assign t_sat = TIME_WIDTH'(edge_interval);
		end else begin : g_narrow
			assign t_sat = (|edge_interval[cei_pkg::EDGE_W-1:TIME_WIDTH]) ? '1 :
			               edge_interval[TIME_WIDTH-1:0];
		end
	endgenerate

	assign glitch    = CMP_W'(t_sat) <  CMP_W'(cfg.noise_limit);
	assign long_idle = CMP_W'(t_sat) >= CMP_W'(cfg.eof_time);

	// Glitches never reach the back end; they change no state.
	assign mid_push = push && !mid_full && !glitch;
	assign mid_data = {long_idle, t_sat};

endmodule
`default_nettype wire

[design/cei_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder back end
// Holds the line state and turns intervals into frame starts, and into runs with a serial divider.
// ----------------------------------------------------------------------------
module cei_back #(
	parameter int TIME_WIDTH = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cei_pkg::cfg_t     cfg,
	input  wire logic              mid_empty,
	input  wire logic [TIME_WIDTH:0] mid_data,
	output logic                   mid_pop,
	input  wire logic              out_full,
	output logic                   out_push,
	output cei_pkg::result_t       out_data
);

	localparam int CNT_W = $clog2(TIME_WIDTH);
	localparam int RAW_W = TIME_WIDTH + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} bk_state_t;

	bk_state_t             state_q;
	logic                  line_level_q;
	logic                  prev_five_q;
	logic                  overload_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_WIDTH-1:0] quo_q;
	logic [15:0]           rem_q;
	cei_pkg::result_t      res_q;

	logic                  in_long;
	logic [TIME_WIDTH-1:0] in_time;
	logic [15:0]           bt;
	logic [16:0]           trial;
	logic                  trial_ge;
	logic [15:0]           rem_next;
	logic                  round_up;
	logic [RAW_W-1:0]      raw;
	logic [RAW_W-1:0]      run;
	logic                  run_over;
	logic                  run_emit;

	assign in_long = mid_data[TIME_WIDTH];
	assign in_time = mid_data[TIME_WIDTH-1:0];
	assign bt      = (cfg.bit_time == '0) ? 16'd1 : cfg.bit_time;

	// One restoring divide step per cycle.
	assign trial    = {rem_q, quo_q[TIME_WIDTH-1]};
	assign trial_ge = trial >= {1'b0, bt};
	assign rem_next = trial_ge ? 16'(trial - {1'b0, bt}) : trial[15:0];

	// Round to nearest, then strip the stuff bit. A raw count of zero with a
	// pending stuff bit wraps to all ones and so lands in the overload case.
	assign round_up = rem_q >= (bt >> 1);
	assign raw      = {1'b0, quo_q} + RAW_W'(round_up);
	assign run      = prev_five_q ? raw - 1'b1 : raw;
	assign run_over = run > RAW_W'(cei_pkg::RUN_MAX);
	assign run_emit = !run_over && (run != '0);

	assign mid_pop  = (state_q == ST_IDLE) && !mid_empty;
	assign out_push = (state_q == ST_OUT) && !out_full;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_level_q <= 1'b1;
			prev_five_q  <= 1'b0;
			overload_q   <= 1'b0;
			cnt_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!mid_empty) begin
						if (in_long && line_level_q) begin
							line_level_q <= 1'b0;
							overload_q   <= 1'b0;
							state_q      <= ST_OUT;
						end else if (!overload_q) begin
							cnt_q   <= CNT_W'(TIME_WIDTH - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					line_level_q <= !line_level_q;
					prev_five_q  <= (raw == RAW_W'(cei_pkg::RUN_MAX));
					if (run_over) begin
						overload_q <= 1'b1;
					end
					state_q <= run_emit ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			quo_q <= in_time;
			rem_q <= '0;
			res_q <= '{frame_start: 1'b1, run_level: 1'b0, run_length: '0};
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[TIME_WIDTH-2:0], trial_ge};
			rem_q <= rem_next;
		end else if (state_q == ST_FIN) begin
			res_q <= '{frame_start: 1'b0, run_level: line_level_q,
			           run_length: run[cei_pkg::RUN_LEN_W-1:0]};
		end
	end

endmodule
`default_nettype wire

[design/can_edge_interval_run_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder
// Turns times between CAN line edges into frame starts and destuffed bit runs.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ---------------------------------------
//  input     push / full        edge_interval
//  result    empty / pop        frame_start, run_level, run_length
//  config    cfg_we             cfg_index, cfg_data
//
// A run edge that yields a run passes the back end in order: the request
// is taken, the restoring divider finds one quotient bit per cycle, the
// result is rounded and classified, and it is handed to the output queue.
// A run edge that yields no result leaves after the rounding step. A frame
// start is taken and then handed over without a divide, and an edge
// dropped while in overload is only taken. Glitches are removed at the
// front end and cost the back end nothing. A full output queue holds the
// back end in its hand-off step.
// Reset brings the line to recessive with no stuff bit pending and no error.
// Two-entry queues sit before and after the back end, so input requests
// keep flowing while a result waits to be popped.
//
module can_edge_interval_run_decoder #(
	parameter int TIME_WIDTH = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input request queue.
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [cei_pkg::EDGE_W-1:0]      edge_interval,
	// Result queue.
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 frame_start,
	output logic                                 run_level,
	output logic [cei_pkg::RUN_LEN_W-1:0]        run_length,
	// Configuration writes.
	input  wire logic                            cfg_we,
	input  wire logic [cei_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [cei_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int MID_W = TIME_WIDTH + 1;
	localparam int RES_W = $bits(cei_pkg::result_t);

	cei_pkg::cfg_t    cfg_q;
	logic             mid_push;
	logic [MID_W-1:0] mid_wr_data;
	logic             mid_full;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rd_data;
	logic             mid_empty;
	logic             out_push;
	cei_pkg::result_t out_wr_data;
	logic             out_full;
	logic [RES_W-1:0] out_rd_data;
	cei_pkg::result_t out_res;

	// Configuration registers. Writes to an unused index are ignored, and
	// each register keeps only as many bits as it is wide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_time    <= cei_pkg::BIT_TIME_RST;
			cfg_q.noise_limit <= cei_pkg::NOISE_LIMIT_RST;
			cfg_q.eof_time    <= cei_pkg::EOF_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cei_pkg::REG_BIT_TIME:    cfg_q.bit_time    <= cfg_data[15:0];
				cei_pkg::REG_NOISE_LIMIT: cfg_q.noise_limit <= cfg_data[15:0];
				cei_pkg::REG_EOF_TIME:    cfg_q.eof_time    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end accepts whenever the middle queue has room, so the
	// input queue appears full exactly when the middle queue is.
	assign full = mid_full;

	cei_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.cfg           (cfg_q),
		.push          (push),
		.edge_interval (edge_interval),
		.mid_full      (mid_full),
		.mid_push      (mid_push),
		.mid_data      (mid_wr_data)
	);

	cei_queue #(
		.WIDTH (MID_W),
		.DEPTH (cei_pkg::QUEUE_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.wr_data (mid_wr_data),
		.full    (mid_full),
		.pop     (mid_pop),
		.rd_data (mid_rd_data),
		.empty   (mid_empty)
	);

	cei_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_data  (mid_rd_data),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_wr_data)
	);

	cei_queue #(
		.WIDTH (RES_W),
		.DEPTH (cei_pkg::QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_wr_data),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_rd_data),
		.empty   (empty)
	);

	assign out_res     = cei_pkg::result_t'(out_rd_data);
	assign frame_start = out_res.frame_start;
	assign run_level   = out_res.run_level;
	assign run_length  = out_res.run_length;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN edge-interval run decoder testbench
// Drives edge intervals through the push/full queue under several register
// settings and checks every popped frame start and destuffed run against an
// in-bench decoder of the line state.
// ----------------------------------------------------------------------------
module tb_top;

	// Write to this index must be ignored by the block.
	localparam logic [cei_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [cei_pkg::EDGE_W-1:0] TIME_MAX = {cei_pkg::EDGE_W{1'b1}};

	// Idle cycles before a register write or the final verdict. They must outlast
	// a run edge in the back end and the edges still waiting in the input queue,
	// so this covers edges that end without any result.
	localparam int SETTLE_CYCLES = 150;
	// Cycles with no request moving on either side before the run is aborted.
	localparam int QUIET_LIMIT   = 4000;
	// Non-glitch edges per random register setting.
	localparam int PHASE_EDGES   = 210;
	// Length of the long receiver hold-off used to back the block up.
	localparam int HOLD_CYCLES   = 400;

	// Line state tracked by the in-bench decoder.
	typedef struct packed {
		logic level;  // 1 recessive
		logic five;   // previous raw count was five, next bit is a stuff bit
		logic ovl;    // sticky overload, cleared at a start of frame
	} line_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            push = 1'b0;
	logic                            full;
	logic [cei_pkg::EDGE_W-1:0]      edge_interval = '0;
	logic                            empty;
	logic                            pop = 1'b0;
	logic                            frame_start;
	logic                            run_level;
	logic [cei_pkg::RUN_LEN_W-1:0]   run_length;
	logic                            cfg_we = 1'b0;
	logic [cei_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [cei_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Shadow of the register file and of the line state, updated as each
	// request is accepted by the block.
	cei_pkg::cfg_t    shadow_cfg;
	line_t            line_st;
	// Frame starts and runs that the block still owes us, oldest first.
	cei_pkg::result_t pending_runs[$];
	int               edges_decoded = 0;
	int               mismatches = 0;
	int               quiet_cycles = 0;
	// Idle controls shared between the stimulus and the receiver.
	bit               tx_no_idle = 1'b0;
	bit               rx_no_idle = 1'b0;
	int               rx_hold_request = 0;

	can_edge_interval_run_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.edge_interval (edge_interval),
		.empty         (empty),
		.pop           (pop),
		.frame_start   (frame_start),
		.run_level     (run_level),
		.run_length    (run_length),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Decoder of one edge. Returns 1 when the edge produces a result, and
	// advances the line state the same way the block must.
	// ------------------------------------------------------------------------
	function automatic logic decode_step(input cei_pkg::cfg_t c, inout line_t s,
			input logic [cei_pkg::EDGE_W-1:0] iv, output cei_pkg::result_t r);
		int unsigned bt;
		int unsigned raw;
		int unsigned run;
		logic        level_was;
		logic        wrap;
		r = '0;
		// Glitches leave everything untouched.
		if (iv < c.noise_limit)
			return 1'b0;
		// A long idle while recessive opens a new frame and clears overload.
		if (iv >= c.eof_time && s.level) begin
			s.level = 1'b0;
			s.ovl = 1'b0;
			r.frame_start = 1'b1;
			return 1'b1;
		end
		// In overload the block stays silent and the level is frozen.
		if (s.ovl)
			return 1'b0;
		// A zero bit time behaves as one tick.
		bt = (c.bit_time == 0) ? 1 : c.bit_time;
		raw = iv / bt;
		if (iv % bt >= bt / 2)
			raw++;
		level_was = s.level;
		s.level = !s.level;
		// Dropping the stuff bit from a zero count underflows into overload.
		wrap = s.five && raw == 0;
		run = s.five ? raw - 1 : raw;
		s.five = (raw == 5);
		if (wrap || run > cei_pkg::RUN_MAX) begin
			s.ovl = 1'b1;
			return 1'b0;
		end
		if (run == 0)
			return 1'b0;
		r.run_level = level_was;
		r.run_length = run[cei_pkg::RUN_LEN_W-1:0];
		return 1'b1;
	endfunction

	// An overload that leaves the line dominant can never be left again, since
	// only a start of frame clears it and that needs a recessive line. Such
	// edges are swapped for a frame start so the run keeps exercising the block.
	function automatic logic locks_line(input logic [cei_pkg::EDGE_W-1:0] iv);
		line_t            s;
		cei_pkg::result_t r;
		logic             produced;
		s = line_st;
		produced = decode_step(shadow_cfg, s, iv, r);
		return !produced && s.ovl && !s.level;
	endfunction

	function automatic logic [cei_pkg::EDGE_W-1:0] clamp_interval(input longint x);
		if (x < 0)
			return '0;
		if (x > longint'(TIME_MAX))
			return TIME_MAX;
		return x[cei_pkg::EDGE_W-1:0];
	endfunction

	function automatic int unsigned eff_bit_time();
		return (shadow_cfg.bit_time == 0) ? 1 : shadow_cfg.bit_time;
	endfunction

	// Idle interval long enough to open a frame, never below the glitch limit.
	function automatic logic [cei_pkg::EDGE_W-1:0] frame_gap();
		longint base;
		base = (shadow_cfg.eof_time > shadow_cfg.noise_limit) ?
			shadow_cfg.eof_time : shadow_cfg.noise_limit;
		return clamp_interval(base + longint'($urandom_range(0, 3 * eff_bit_time())));
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 90)
			return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch report: one line each, counted for the verdict.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Sender: offers one edge request and holds it until the block takes it.
	// The expectation is formed at the accepting edge, in request order.
	// Called and returning at a rising clock edge.
	// ------------------------------------------------------------------------
	task automatic send_edge(input logic [cei_pkg::EDGE_W-1:0] iv);
		logic [cei_pkg::EDGE_W-1:0] v;
		cei_pkg::result_t           r;
		int                         gap;
		v = locks_line(iv) ? frame_gap() : iv;
		push <= 1'b1;
		edge_interval <= v;
		do
			@(posedge clk);
		while (full);
		if (decode_step(shadow_cfg, line_st, v, r))
			pending_runs.push_back(r);
		if (v >= shadow_cfg.noise_limit)
			edges_decoded++;
		// Push stays high straight into the next request when there is no gap.
		gap = (tx_no_idle || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers push and waits until every expected result has been popped.
	task automatic drain_results();
		push <= 1'b0;
		while (pending_runs.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only written with the block fully idle. Edges that end
	// without a result may still be in flight, hence the settle time.
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cei_pkg::CFG_INDEX_W-1:0] idx,
			input logic [cei_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cei_pkg::REG_BIT_TIME:    shadow_cfg.bit_time = data[15:0];
			cei_pkg::REG_NOISE_LIMIT: shadow_cfg.noise_limit = data[15:0];
			cei_pkg::REG_EOF_TIME:    shadow_cfg.eof_time = data[19:0];
			default: ;
		endcase
		// A quiet edge with the write enable low ends each write, so back-to-back
		// writes never drop and raise the write enable at the same edge.
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [15:0] bt, input logic [15:0] nl,
			input logic [19:0] eof);
		wait_idle();
		write_reg(cei_pkg::REG_BIT_TIME, cei_pkg::CFG_DATA_W'(bt));
		write_reg(cei_pkg::REG_NOISE_LIMIT, cei_pkg::CFG_DATA_W'(nl));
		write_reg(cei_pkg::REG_EOF_TIME, eof);
	endtask

	// ------------------------------------------------------------------------
	// Well-formed frame: an idle gap that opens the frame, then runs of one to
	// five bits around the nominal bit time, with a stuff bit after every run
	// of five. A few runs are off-size or preceded by a glitch.
	// ------------------------------------------------------------------------
	task automatic send_frame(input int n_runs);
		int unsigned bt;
		int          raw;
		int          jitter;
		bt = eff_bit_time();
		send_edge(frame_gap());
		// Opening on a dominant line does not start a frame; try again.
		if (line_st.level)
			send_edge(frame_gap());
		for (int i = 0; i < n_runs; i++) begin
			if ($urandom_range(0, 99) < 5 && shadow_cfg.noise_limit != 0)
				send_edge(cei_pkg::EDGE_W'($urandom_range(0, shadow_cfg.noise_limit - 1)));
			if ($urandom_range(0, 99) < 8)
				raw = $urandom_range(0, 9);
			else if (line_st.five)
				raw = $urandom_range(2, 6);
			else
				raw = $urandom_range(1, 5);
			jitter = int'($urandom_range(0, bt - 1)) - int'(bt / 2);
			send_edge(clamp_interval(longint'(raw) * longint'(bt) + longint'(jitter)));
		end
	endtask

	// Unstructured edges: anything in the field, or anything near a few bits.
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				send_edge(cei_pkg::EDGE_W'($urandom_range(0, TIME_MAX)));
			else
				send_edge(clamp_interval(longint'($urandom_range(0, 8 * eff_bit_time()))));
		end
	endtask

	// ------------------------------------------------------------------------
	// Test: reset values. Glitches, a run before any frame, an overload that
	// is left only by a start of frame, destuffed runs of one, two, four and
	// five bits, a stuff bit that leaves nothing, and a count above five.
	// ------------------------------------------------------------------------
	task automatic run_directed_defaults();
		send_edge(20'd0);        // glitch
		send_edge(20'd1);        // glitch
		send_edge(20'd2);        // one bit, rounded up, before any frame
		send_edge(TIME_MAX);     // dominant line, huge count: overload
		send_edge(20'd10);       // silenced by overload
		send_edge(20'd42);       // exactly the end-of-frame time: frame start
		send_edge(20'd4);
		send_edge(20'd9);
		send_edge(20'd14);
		send_edge(20'd20);       // five bits, next run carries a stuff bit
		send_edge(20'd24);       // six raw bits less the stuff bit
		send_edge(20'd21);       // five again
		send_edge(20'd5);        // only the stuff bit: no result
		send_edge(20'd100);      // recessive and long: frame start
		send_edge(20'd28);       // seven bits: overload
		send_edge(TIME_MAX);     // frame start clears overload
	endtask

	// ------------------------------------------------------------------------
	// Test: register corners. Zero bit time, no glitch filter, a write with
	// bits above the register width, a write to an unused index, a stuff bit
	// taken from a zero count, and every register at its top value.
	// ------------------------------------------------------------------------
	task automatic run_directed_corners();
		apply_setting(16'd0, 16'd0, cei_pkg::EOF_TIME_RST);
		send_edge(20'd0);        // no filter: a zero interval is a run
		send_edge(20'd3);
		send_edge(20'd4);        // five bits
		send_edge(20'd0);        // stuff bit alone
		wait_idle();
		// Upper bits of the write data must be dropped.
		write_reg(cei_pkg::REG_BIT_TIME, 20'hF0008);
		write_reg(REG_UNUSED, 20'hFFFFF);
		send_edge(20'd8);
		send_edge(20'd40);       // five bits
		send_edge(20'd1);        // rounds to zero, stuff removal underflows
		send_edge(20'd42);       // frame start
		apply_setting(16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_edge(TIME_MAX);     // dominant, sixteen bits: overload
		send_edge(TIME_MAX);     // recessive at the top value: frame start
		send_edge(20'd65534);    // one tick under the glitch limit
		send_edge(20'd65535);    // one bit
	endtask

	// ------------------------------------------------------------------------
	// Test: random frames and noise under one register setting.
	// ------------------------------------------------------------------------
	task automatic run_random_setting(input logic [15:0] bt, input logic [15:0] nl,
			input logic [19:0] eof, input bit no_idle);
		int start;
		apply_setting(bt, nl, eof);
		tx_no_idle = no_idle;
		rx_no_idle = no_idle;
		start = edges_decoded;
		while (edges_decoded - start < PHASE_EDGES) begin
			if ($urandom_range(0, 99) < 85)
				send_frame($urandom_range(1, 25));
			else
				send_noise($urandom_range(1, 4));
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Test: the receiver holds off for a long time while edges keep coming
	// back to back, so both queues fill and full must hold the sender off.
	// ------------------------------------------------------------------------
	task automatic run_fill_and_stall();
		apply_setting(cei_pkg::BIT_TIME_RST, cei_pkg::NOISE_LIMIT_RST,
			cei_pkg::EOF_TIME_RST);
		rx_hold_request = HOLD_CYCLES;
		tx_no_idle = 1'b1;
		send_frame(16);
		tx_no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Test: the sender stops until every result is out, then resumes in the
	// middle of the line state it left.
	// ------------------------------------------------------------------------
	task automatic run_drain_pause();
		send_frame(10);
		drain_results();
		send_frame(10);
		drain_results();
		send_noise(3);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: pops with random stalls, or without any, and honors a long
	// hold-off request counted here.
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				stall = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (!rx_no_idle && $urandom_range(0, 99) < 25)
					stall = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result check: every popped result against the oldest expectation.
	// Outputs are sampled at the edge, before the block updates them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cei_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_runs.size() == 0) begin
				report_mismatch("result with none expected",
					32'({frame_start, run_level, run_length}), 'x);
			end else begin
				want = pending_runs.pop_front();
				if (frame_start !== want.frame_start)
					report_mismatch("frame_start", 32'(frame_start),
						32'(want.frame_start));
				if (run_level !== want.run_level)
					report_mismatch("run_level", 32'(run_level), 32'(want.run_level));
				if (run_length !== want.run_length)
					report_mismatch("run_length", 32'(run_length),
						32'(want.run_length));
			end
		end
	end

	// Watchdog: aborts when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("can_edge_interval_run_decoder: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		shadow_cfg.bit_time = cei_pkg::BIT_TIME_RST;
		shadow_cfg.noise_limit = cei_pkg::NOISE_LIMIT_RST;
		shadow_cfg.eof_time = cei_pkg::EOF_TIME_RST;
		line_st = '{level: 1'b1, five: 1'b0, ovl: 1'b0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed_defaults();
		run_directed_corners();
		run_fill_and_stall();
		run_random_setting(cei_pkg::BIT_TIME_RST, cei_pkg::NOISE_LIMIT_RST,
			cei_pkg::EOF_TIME_RST, 1'b0);
		run_random_setting(16'd1, 16'd0, 20'd11, 1'b1);
		run_random_setting(16'd10, 16'd3, 20'd1000, 1'b0);
		run_drain_pause();
		run_random_setting(16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0);
		run_random_setting(16'd250, 16'd0, 20'd1, 1'b0);
		run_random_setting(16'd3, 16'd1, 20'd33, 1'b1);
		run_random_setting(16'd2, 16'd1, 20'd20, 1'b0);

		// Everything owed must arrive, and nothing more may follow.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("can_edge_interval_run_decoder: match");
		else
			$display("can_edge_interval_run_decoder: mismatch");
		$finish;
	end

endmodule
